FILE: rtl/tta_pkg.sv
package tta_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int TABLE_LEN        = 24;
  localparam int CNT_W            = 5;
  localparam int GUARD_BITS       = 8;
  localparam int CORDIC_W         = 27;

  localparam int ACC_W      = 16;
  localparam int ANG_W      = 15;
  localparam int AVG_W      = 16;
  localparam int DRV_W      = 16;
  localparam int WEIGHT_W   = 16;
  localparam int GAIN_W     = 8;
  localparam int LIMIT_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [ACC_W-1:0] accel_t;
  typedef logic signed [ANG_W-1:0] angle_t;
  typedef logic signed [AVG_W-1:0] avg_t;
  typedef logic signed [DRV_W-1:0] drive_t;

  localparam angle_t HALF_PI = 15'sd12868;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT      = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd6554;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 8'd64;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd10240;

  // atan(2^-i) in Q0.32
  localparam logic [31:0] ATAN_Q32 [TABLE_LEN] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512
  };

endpackage

FILE: rtl/tta_in_if.sv
interface tta_in_if;
  logic            valid;
  logic            ready;
  tta_pkg::accel_t accel_x;
  tta_pkg::accel_t accel_y;
  tta_pkg::accel_t accel_z;
  logic            restart;

  modport source(output valid, accel_x, accel_y, accel_z, restart, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, restart, output ready);
endinterface

FILE: rtl/tta_out_if.sv
interface tta_out_if;
  logic            valid;
  logic            ready;
  tta_pkg::angle_t tilt_pitch;
  tta_pkg::angle_t tilt_roll;
  tta_pkg::angle_t smooth_pitch;
  tta_pkg::angle_t smooth_roll;
  tta_pkg::drive_t drive_x;
  tta_pkg::drive_t drive_y;

  modport source(output valid, tilt_pitch, tilt_roll, smooth_pitch, smooth_roll,
                 drive_x, drive_y, input ready);
  modport sink(input valid, tilt_pitch, tilt_roll, smooth_pitch, smooth_roll,
               drive_x, drive_y, output ready);
endinterface

FILE: rtl/tilt_to_acceleration_filter_unit.sv
// channel   dir  handshake     word
// in_ch     in   valid/ready   accel_x, accel_y, accel_z, restart
// out_ch    out  valid/ready   tilt_pitch, tilt_roll, smooth_pitch, smooth_roll,
//                              drive_x, drive_y
// cfg       in   cfg_we        cfg_index, cfg_data
//
// A word passes from accept to out_ch.valid through these steps:
// one CORDIC rotation per cycle on both lanes, then a bit-serial weight
// multiply and a bit-serial gain multiply. The next word is accepted as
// soon as the result moves to the output register, even while it waits there.
// rst_n is synchronous; it clears control and averages and loads the config registers with their reset values.
// A stall on out_ch holds the finished result in the sequencer until the output
// register frees.
module tilt_to_acceleration_filter_unit #(
  parameter int CORDIC_STEPS = tta_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_WIDTH  = tta_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tta_in_if.sink                           in_ch,
  tta_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [tta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tta_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW     = tta_pkg::CORDIC_W;
  localparam int CNTW   = tta_pkg::CNT_W;
  localparam int NSTEPS = (CORDIC_STEPS > tta_pkg::TABLE_LEN) ? tta_pkg::TABLE_LEN
                                                              : CORDIC_STEPS;
  localparam int FRAC   = ANGLE_WIDTH - 3;
  localparam int SH     = 32 - FRAC;
  localparam int EW     = ANGLE_WIDTH + 5;
  localparam int RSH    = (FRAC > 13) ? FRAC - 13 : 0;
  localparam int LSH    = (FRAC < 13) ? 13 - FRAC : 0;
  localparam int RND_I  = (1 << RSH) >> 1;
  localparam logic signed [EW-1:0] RND = EW'(RND_I);
  localparam logic [32:0] TBL_RND = 33'(1) << (SH - 1);

  localparam logic [CNTW-1:0] ROT_LAST = CNTW'(NSTEPS - 1);
  localparam logic [CNTW-1:0] AVG_LAST = CNTW'(tta_pkg::WEIGHT_W - 1);
  localparam logic [CNTW-1:0] DRV_LAST = CNTW'(tta_pkg::GAIN_W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT  = 3'd1;
  localparam logic [2:0] S_ANG  = 3'd2;
  localparam logic [2:0] S_AVG  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DRV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]      state_r;
  logic [CNTW-1:0] cnt_r;
  logic            out_valid_r;

  logic [tta_pkg::WEIGHT_W-1:0] weight_r;
  logic [tta_pkg::GAIN_W-1:0]   gain_r;
  logic [tta_pkg::LIMIT_W-1:0]  limit_r;

  logic signed [CW-1:0]          x_r [2];
  logic signed [CW-1:0]          y_r [2];
  logic signed [ANGLE_WIDTH-1:0] z_r [2];
  logic                          spec_r [2];
  tta_pkg::angle_t               spec_val_r [2];
  tta_pkg::angle_t               ang_r [2];
  tta_pkg::avg_t                 avg_r [2];
  logic signed [16:0]            hi_r [2];
  logic [1:0]                    lo_r [2];
  logic [tta_pkg::WEIGHT_W-1:0]  mul_sr_r;

  tta_pkg::angle_t out_tilt_r [2];
  tta_pkg::angle_t out_smooth_r [2];
  tta_pkg::drive_t out_drv_r [2];

  logic signed [CW-1:0]          x_nxt [2];
  logic signed [CW-1:0]          y_nxt [2];
  logic signed [ANGLE_WIDTH-1:0] z_nxt [2];
  logic signed [CW-1:0]          x_init [2];
  logic signed [CW-1:0]          y_init [2];
  logic                          spec_init [2];
  tta_pkg::angle_t               sval_init [2];
  tta_pkg::angle_t               ang_nxt [2];
  tta_pkg::avg_t                 avg_nxt [2];
  logic signed [16:0]            hi_nxt [2];
  logic [1:0]                    lo_nxt [2];
  tta_pkg::drive_t               drv_val [2];

  logic                          in_acc;
  logic                          out_ld;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ld       = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tilt_pitch   = out_tilt_r[0];
  assign out_ch.tilt_roll    = out_tilt_r[1];
  assign out_ch.smooth_pitch = out_smooth_r[0];
  assign out_ch.smooth_roll  = out_smooth_r[1];
  assign out_ch.drive_x      = out_drv_r[1];
  assign out_ch.drive_y      = out_drv_r[0];

  always_comb begin
    logic [32:0]                  t_sum;
    logic signed [ANGLE_WIDTH-1:0] t_step;
    logic signed [CW-1:0]         xs;
    logic signed [CW-1:0]         ys;
    logic signed [16:0]           num [2];
    logic signed [16:0]           den;
    logic signed [16:0]           absd;
    logic signed [16:0]           nume;
    logic signed [EW-1:0]         z_ext;
    logic signed [EW-1:0]         z_q;
    logic signed [EW-1:0]         lim_a;
    logic signed [16:0]           mcand;
    logic signed [17:0]           mul_s;
    logic signed [17:0]           avg_sum;
    logic signed [18:0]           drv_sum;
    logic signed [18:0]           lim_d;
    t_sum  = {1'b0, tta_pkg::ATAN_Q32[cnt_r]} + TBL_RND;
    t_step = ANGLE_WIDTH'(t_sum >> SH);
    num[0] = 17'(in_ch.accel_y);
    num[1] = -17'(in_ch.accel_x);
    den    = 17'(in_ch.accel_z);
    absd   = den[16] ? -den : den;
    lim_a  = EW'(tta_pkg::HALF_PI);
    lim_d  = 19'(limit_r);
    for (int l = 0; l < 2; l++) begin
      // rotate toward the x axis
      xs = x_r[l] >>> cnt_r;
      ys = y_r[l] >>> cnt_r;
      if (y_r[l] > 0) begin
        x_nxt[l] = x_r[l] + ys;
        y_nxt[l] = y_r[l] - xs;
        z_nxt[l] = z_r[l] + t_step;
      end else begin
        x_nxt[l] = x_r[l] - ys;
        y_nxt[l] = y_r[l] + xs;
        z_nxt[l] = z_r[l] - t_step;
      end

      nume      = den[16] ? -num[l] : num[l];
      x_init[l] = CW'(absd) <<< tta_pkg::GUARD_BITS;
      y_init[l] = CW'(nume) <<< tta_pkg::GUARD_BITS;
      spec_init[l] = (den == '0) || (num[l] == '0);
      if (den != '0 || num[l] == '0) begin
        sval_init[l] = '0;
      end else if (num[l] > 0) begin
        sval_init[l] = tta_pkg::HALF_PI;
      end else begin
        sval_init[l] = -tta_pkg::HALF_PI;
      end

      z_ext = EW'(z_r[l]);
      z_q   = ((z_ext + RND) >>> RSH) <<< LSH;
      if (spec_r[l]) begin
        ang_nxt[l] = spec_val_r[l];
      end else if (z_q > lim_a) begin
        ang_nxt[l] = tta_pkg::HALF_PI;
      end else if (z_q < -lim_a) begin
        ang_nxt[l] = -tta_pkg::HALF_PI;
      end else begin
        ang_nxt[l] = tta_pkg::ANG_W'(z_q);
      end

      // shift-add multiply, multiplier LSB first
      if (state_r == S_AVG) begin
        mcand = 17'(ang_r[l]) - 17'(avg_r[l]);
      end else begin
        mcand = 17'(avg_r[l]);
      end
      mul_s     = 18'(hi_r[l]) + (mul_sr_r[0] ? 18'(mcand) : 18'sd0);
      hi_nxt[l] = 17'(mul_s >>> 1);
      lo_nxt[l] = {mul_s[0], lo_r[l][1]};

      avg_sum = 18'(avg_r[l]) + 18'(hi_r[l]) + 18'({1'b0, lo_r[l][1]});
      if (avg_sum > 18'(tta_pkg::HALF_PI)) begin
        avg_nxt[l] = 16'(tta_pkg::HALF_PI);
      end else if (avg_sum < -18'(tta_pkg::HALF_PI)) begin
        avg_nxt[l] = -16'(tta_pkg::HALF_PI);
      end else begin
        avg_nxt[l] = 16'(avg_sum);
      end

      drv_sum = (19'(hi_r[l]) <<< 1) + 19'({1'b0, lo_r[l][1]}) + 19'({1'b0, lo_r[l][0]});
      if (drv_sum > lim_d) begin
        drv_val[l] = 16'(lim_d);
      end else if (drv_sum < -lim_d) begin
        drv_val[l] = 16'(-lim_d);
      end else begin
        drv_val[l] = 16'(drv_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= tta_pkg::WEIGHT_RST;
      gain_r   <= tta_pkg::GAIN_RST;
      limit_r  <= tta_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tta_pkg::CFG_SMOOTHING_WEIGHT: weight_r <= cfg_data;
        tta_pkg::CFG_TILT_GAIN:        gain_r   <= cfg_data[tta_pkg::GAIN_W-1:0];
        tta_pkg::CFG_ACCEL_LIMIT:      limit_r  <= cfg_data[tta_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      avg_r[0]    <= '0;
      avg_r[1]    <= '0;
    end else begin
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            for (int l = 0; l < 2; l++) begin
              x_r[l]        <= x_init[l];
              y_r[l]        <= y_init[l];
              z_r[l]        <= '0;
              spec_r[l]     <= spec_init[l];
              spec_val_r[l] <= sval_init[l];
              if (in_ch.restart) begin
                avg_r[l] <= '0;
              end
            end
            cnt_r   <= '0;
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          for (int l = 0; l < 2; l++) begin
            x_r[l] <= x_nxt[l];
            y_r[l] <= y_nxt[l];
            z_r[l] <= z_nxt[l];
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ROT_LAST) begin
            state_r <= S_ANG;
          end
        end
        S_ANG: begin
          for (int l = 0; l < 2; l++) begin
            ang_r[l] <= ang_nxt[l];
            hi_r[l]  <= '0;
            lo_r[l]  <= '0;
          end
          mul_sr_r <= weight_r;
          cnt_r    <= '0;
          state_r  <= S_AVG;
        end
        S_AVG: begin
          for (int l = 0; l < 2; l++) begin
            hi_r[l] <= hi_nxt[l];
            lo_r[l] <= lo_nxt[l];
          end
          mul_sr_r <= mul_sr_r >> 1;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == AVG_LAST) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          for (int l = 0; l < 2; l++) begin
            avg_r[l] <= avg_nxt[l];
            hi_r[l]  <= '0;
            lo_r[l]  <= '0;
          end
          mul_sr_r <= tta_pkg::WEIGHT_W'(gain_r);
          cnt_r    <= '0;
          state_r  <= S_DRV;
        end
        S_DRV: begin
          for (int l = 0; l < 2; l++) begin
            hi_r[l] <= hi_nxt[l];
            lo_r[l] <= lo_nxt[l];
          end
          mul_sr_r <= mul_sr_r >> 1;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == DRV_LAST) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ld) begin
            for (int l = 0; l < 2; l++) begin
              out_tilt_r[l]   <= ang_r[l];
              out_smooth_r[l] <= tta_pkg::ANG_W'(avg_r[l]);
              out_drv_r[l]    <= drv_val[l];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_accept_starts_rot: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_ROT) && (cnt_r == '0))
    else $error("accepted word did not start rotation");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (cnt_r <= ROT_LAST))
    else $error("rotation count overrun");

  a_avg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (avg_r[0] <= 16'(tta_pkg::HALF_PI)) && (avg_r[0] >= -16'(tta_pkg::HALF_PI)) &&
    (avg_r[1] <= 16'(tta_pkg::HALF_PI)) && (avg_r[1] >= -16'(tta_pkg::HALF_PI)))
    else $error("average out of range");

endmodule
